FILE: rtl/rcpd_pkg.sv
package rcpd_pkg;

    // Field widths of the stream and configuration ports
    localparam int PULSE_W    = 15;
    localparam int NOW_W      = 32;
    localparam int DB_W       = 7;
    localparam int TMO_W      = 16;
    localparam int DUTY_W     = 7;
    localparam int SPEED_W    = 8;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_FIELDS_W = PULSE_W + NOW_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 4 * DUTY_W + SPEED_W + STAT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Reset values
    localparam logic [PULSE_W-1:0] RST_PULSE_MIN  = PULSE_W'(445);
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX  = PULSE_W'(800);
    localparam logic [DB_W-1:0]    RST_DEADBAND   = DB_W'(10);
    localparam logic [TMO_W-1:0]   RST_TIMEOUT    = TMO_W'(2000);
    localparam logic [PULSE_W-1:0] RST_LAST_PULSE = PULSE_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_MIN = 2'd0,
        CFG_PULSE_MAX = 2'd1,
        CFG_DEADBAND  = 2'd2,
        CFG_TIMEOUT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_DRIVE = 2'd0,
        ST_LOST  = 2'd1,
        ST_ARM   = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic cap;
        logic upd;
        logic med;
        logic map_go;
        logic map_take;
        logic arm;
        logic resc_go;
        logic resc_take;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic lost;
        logic empty;
        logic need_resc;
        logic div_busy;
        logic div_done;
    } t_dp_stat;

endpackage

FILE: rtl/rcpd_div.sv
module rcpd_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_den;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // Restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/rcpd_dp.sv
module rcpd_dp #(
    parameter int FULL_SCALE = 127
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [rcpd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic [rcpd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  rcpd_pkg::t_cmd                   i_cmd,
    output rcpd_pkg::t_dp_stat               o_st
);

    localparam int PW  = rcpd_pkg::PULSE_W;
    localparam int FSW = $clog2(FULL_SCALE + 1);
    localparam int K2W = $clog2(2 * FULL_SCALE + 1);
    localparam int DW  = PW + K2W;
    localparam int MW  = DW + 2;

    localparam logic [K2W-1:0] K_TWO_FS = K2W'(2 * FULL_SCALE);
    localparam logic [FSW-1:0] FS_U     = FSW'(FULL_SCALE);
    localparam logic [MW-1:0]  FS_M     = MW'(FULL_SCALE);
    localparam logic [PW-1:0]  FS_P     = PW'(FULL_SCALE);

    // Configuration
    logic [PW-1:0]                   r_min;
    logic [PW-1:0]                   r_max;
    logic [rcpd_pkg::DB_W-1:0]       r_db;
    logic [rcpd_pkg::TMO_W-1:0]      r_tmo;

    // Held state
    logic [PW-1:0]                   r_last;
    logic [rcpd_pkg::NOW_W-1:0]      r_lchg;
    logic [PW-1:0]                   r_h0;
    logic [PW-1:0]                   r_h1;
    logic [PW-1:0]                   r_h2;
    logic                            r_waiting;

    // Per-item working registers
    logic [PW-1:0]                   r_pulse;
    logic [rcpd_pkg::NOW_W-1:0]      r_now;
    logic [PW-1:0]                   r_med;
    logic                            r_neg;
    logic [MW-1:0]                   r_mapped;
    logic [FSW-1:0]                  r_cmag;
    logic [rcpd_pkg::SPEED_W-1:0]    r_speed;
    logic [rcpd_pkg::DUTY_W-1:0]     r_duty;
    logic                            r_drive;
    logic                            r_fwd;
    rcpd_pkg::t_status               r_stat;
    logic [rcpd_pkg::M_TDATA_W-1:0]  r_out;

    logic [rcpd_pkg::NOW_W-1:0]      w_elapsed;
    logic                            w_lost;
    logic                            w_empty;
    logic [PW-1:0]                   w_lo;
    logic [PW-1:0]                   w_hi;
    logic [PW-1:0]                   w_median;
    logic [PW:0]                     w_diff;
    logic [PW:0]                     w_dabs;
    logic [DW-1:0]                   w_num;
    logic [PW-1:0]                   w_rdiff;
    logic [DW-1:0]                   w_div_a;
    logic [PW-1:0]                   w_div_b;
    logic [DW-1:0]                   w_quo;
    logic                            w_div_busy;
    logic                            w_div_done;
    logic [MW-1:0]                   w_qx;
    logic [MW-1:0]                   w_mabs;
    logic [FSW-1:0]                  w_mag;
    logic                            w_sign;
    logic                            w_drive;
    logic                            w_db_full;
    logic [rcpd_pkg::SPEED_W-1:0]    w_speed;
    logic [rcpd_pkg::DUTY_W-1:0]     w_ha;
    logic [rcpd_pkg::DUTY_W-1:0]     w_hc;
    logic [rcpd_pkg::DUTY_W-1:0]     w_lc;
    logic [rcpd_pkg::DUTY_W-1:0]     w_la;

    // Signal loss: a changed pulse restarts the timer, so only a repeat can time out
    assign w_elapsed = r_now - r_lchg;
    assign w_lost    = (r_pulse == '0) ||
                       ((r_pulse == r_last) &&
                        (w_elapsed > rcpd_pkg::NOW_W'(r_tmo)));
    assign w_empty   = (r_max <= r_min);

    // Median of three
    assign w_lo     = (r_h0 < r_h1) ? r_h0 : r_h1;
    assign w_hi     = (r_h0 < r_h1) ? r_h1 : r_h0;
    assign w_median = (r_h2 <= w_lo) ? w_lo : ((r_h2 >= w_hi) ? w_hi : r_h2);

    // Range mapping numerator, sign and magnitude
    assign w_diff = {1'b0, r_med} - {1'b0, r_min};
    assign w_dabs = w_diff[PW] ? ((PW + 1)'(0) - w_diff) : w_diff;
    assign w_num  = DW'(w_dabs[PW-1:0]) * DW'(K_TWO_FS);

    // Rescale numerator: magnitude is at least the deadband here
    assign w_rdiff = PW'(r_cmag) - PW'(r_db);

    assign w_div_a = i_cmd.resc_go ? (DW'(w_rdiff) * DW'(FS_U)) : w_num;
    assign w_div_b = i_cmd.resc_go ? (FS_P - PW'(r_db)) : (r_max - r_min);

    rcpd_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.map_go | i_cmd.resc_go),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_qx = MW'(w_quo);

    // Clamp and deadband decisions on the mapped value
    assign w_sign    = r_mapped[MW-1];
    assign w_mabs    = w_sign ? (MW'(0) - r_mapped) : r_mapped;
    assign w_mag     = (w_mabs > FS_M) ? FS_U : FSW'(w_mabs);
    assign w_drive   = (PW'(w_mag) >= PW'(r_db)) && (w_mag != '0);
    assign w_db_full = (PW'(r_db) >= FS_P);
    assign w_speed   = w_sign ? (rcpd_pkg::SPEED_W'(0) - rcpd_pkg::SPEED_W'(w_mag))
                              : rcpd_pkg::SPEED_W'(w_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= rcpd_pkg::RST_PULSE_MIN;
            r_max     <= rcpd_pkg::RST_PULSE_MAX;
            r_db      <= rcpd_pkg::RST_DEADBAND;
            r_tmo     <= rcpd_pkg::RST_TIMEOUT;
            r_last    <= rcpd_pkg::RST_LAST_PULSE;
            r_lchg    <= '0;
            r_h0      <= '0;
            r_h1      <= '0;
            r_h2      <= '0;
            r_waiting <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (rcpd_pkg::t_cfg_idx'(i_cfg_idx))
                    rcpd_pkg::CFG_PULSE_MIN: r_min <= i_cfg_data[PW-1:0];
                    rcpd_pkg::CFG_PULSE_MAX: r_max <= i_cfg_data[PW-1:0];
                    rcpd_pkg::CFG_DEADBAND:  r_db  <= i_cfg_data[rcpd_pkg::DB_W-1:0];
                    rcpd_pkg::CFG_TIMEOUT:   r_tmo <= i_cfg_data[rcpd_pkg::TMO_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd) begin
                if (r_pulse != r_last) begin
                    r_last <= r_pulse;
                    r_lchg <= r_now;
                end
                if (!w_lost) begin
                    r_h2 <= r_h1;
                    r_h1 <= r_h0;
                    r_h0 <= r_pulse;
                end
            end
            if (i_cmd.arm && r_waiting && (w_mabs < MW'(r_db))) begin
                r_waiting <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pulse <= i_s_tdata[PW-1:0];
            r_now   <= i_s_tdata[rcpd_pkg::S_FIELDS_W-1:PW];
        end
        if (i_cmd.upd && w_lost) begin
            r_stat  <= rcpd_pkg::ST_LOST;
            r_speed <= '0;
            r_drive <= 1'b0;
        end
        if (i_cmd.med) begin
            r_med <= w_median;
        end
        if (i_cmd.map_go) begin
            r_neg <= w_diff[PW];
        end
        if (i_cmd.map_take) begin
            r_mapped <= w_empty ? '0 : ((r_neg ? (MW'(0) - w_qx) : w_qx) - FS_M);
        end
        if (i_cmd.arm) begin
            r_speed <= w_speed;
            r_stat  <= r_waiting ? rcpd_pkg::ST_ARM : rcpd_pkg::ST_DRIVE;
            r_drive <= !r_waiting && w_drive;
            r_fwd   <= !w_sign;
            r_cmag  <= w_mag;
            r_duty  <= rcpd_pkg::DUTY_W'(FULL_SCALE);
        end
        if (i_cmd.resc_take) begin
            r_duty <= rcpd_pkg::DUTY_W'(w_quo);
        end
        if (i_cmd.load_out) begin
            r_out <= rcpd_pkg::M_TDATA_W'({r_stat, r_speed, w_la, w_lc, w_hc, w_ha});
        end
    end

    // Chop the high side of the active diagonal, hold its low side on
    assign w_ha = (r_drive && r_fwd)  ? r_duty : '0;
    assign w_hc = (r_drive && !r_fwd) ? r_duty : '0;
    assign w_lc = (r_drive && r_fwd)  ? rcpd_pkg::DUTY_W'(FULL_SCALE) : '0;
    assign w_la = (r_drive && !r_fwd) ? rcpd_pkg::DUTY_W'(FULL_SCALE) : '0;

    assign o_m_tdata      = r_out;
    assign o_st.lost      = w_lost;
    assign o_st.empty     = w_empty;
    assign o_st.need_resc = !r_waiting && w_drive && !w_db_full;
    assign o_st.div_busy  = w_div_busy;
    assign o_st.div_done  = w_div_done;

endmodule

FILE: rtl/rcpd_ctrl.sv
module rcpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  rcpd_pkg::t_dp_stat i_st,
    output rcpd_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MED,
        S_MAP,
        S_MDIV,
        S_ARM,
        S_RGO,
        S_RDIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_st.lost ? S_OUT : S_MED;
            end
            S_MED: begin
                o_cmd.med = 1'b1;
                n_state   = S_MAP;
            end
            S_MAP: begin
                if (i_st.empty) begin
                    o_cmd.map_take = 1'b1;
                    n_state        = S_ARM;
                end else begin
                    o_cmd.map_go = 1'b1;
                    n_state      = S_MDIV;
                end
            end
            S_MDIV: begin
                if (i_st.div_done) begin
                    o_cmd.map_take = 1'b1;
                    n_state        = S_ARM;
                end
            end
            S_ARM: begin
                o_cmd.arm = 1'b1;
                n_state   = i_st.need_resc ? S_RGO : S_OUT;
            end
            S_RGO: begin
                o_cmd.resc_go = 1'b1;
                n_state       = S_RDIV;
            end
            S_RDIV: begin
                if (i_st.div_done) begin
                    o_cmd.resc_take = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDIV || r_state == S_RDIV) |-> (i_st.div_busy || i_st.div_done))
        else $error("waiting on divider that is not running");

    a_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_done |-> (r_state == S_MDIV || r_state == S_RDIV))
        else $error("divider finished outside a wait state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result register reloaded over a pending beat");

endmodule

FILE: rtl/rc_pulse_to_hbridge_drive_unit.sv
// Flow: one item at a time through a shared bit-serial divider (range map, rescale); the
//   input is ready again in the cycle after the result loads. The result register frees
//   the input while a result waits, a second result waits for it.
// Reset (synchronous, active low): configuration defaults, history cleared, disarmed.
module rc_pulse_to_hbridge_drive_unit #(
    parameter int FULL_SCALE = 127
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port: index selects pulse_min_us, pulse_max_us, deadband, timeout_ms
    input  logic                             i_cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input beats
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata from bit 0 up: pulse_us[14:0], now_ms[46:15], zero pad [47]
    input  logic [rcpd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // Result beats
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata from bit 0 up: high_a_duty[6:0], high_c_duty[13:7], low_c_duty[20:14],
    // low_a_duty[27:21], speed[35:28], status[37:36], zero pad [39:38]
    output logic [rcpd_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    // Command and status between the sequencer and the datapath
    rcpd_pkg::t_cmd     w_cmd;
    rcpd_pkg::t_dp_stat w_st;

    // Sequencer: walks each item through update, median, map, arm and rescale as needed,
    // and owns both handshakes
    rcpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // Datapath: configuration, pulse history, timeout check, shared divider,
    // clamp and deadband logic, and the result register
    rcpd_dp #(
        .FULL_SCALE (FULL_SCALE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_st       (w_st)
    );

endmodule
